// ===== rtl/core/iwpu_pkg.sv =====
// ----------------------------------------------------------------------------
// iwpu_pkg
// Shared types, constants and helpers for the ice/water phase update pipeline.
// ----------------------------------------------------------------------------
package iwpu_pkg;

    // phase encoding
    localparam logic [1:0] PH_ICE    = 2'd0;
    localparam logic [1:0] PH_MELT   = 2'd1;
    localparam logic [1:0] PH_FREEZE = 2'd2;
    localparam logic [1:0] PH_WATER  = 2'd3;

    // Q16.16 constants
    localparam logic signed [31:0] T_249 = 32'sd16318464;
    localparam logic signed [31:0] T_250 = 32'sd16384000;
    localparam logic signed [31:0] T_251 = 32'sd16449536;
    localparam logic signed [31:0] C_2P1 = 32'sd137626;
    localparam logic signed [31:0] C_4P2 = 32'sd275251;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // divider geometry
    localparam int DVD_W = 50;   // |137626 * heat| < 2^49
    localparam int DVS_W = 31;   // latent heat width
    localparam int QUO_W = 32;

    localparam int LH_W  = 31;

    typedef struct packed {
        logic [11:0]        tag;
        logic signed [31:0] temp;
        logic signed [31:0] heat;
        logic [1:0]         phase;
        logic signed [31:0] dt;
        logic               flag;
        logic               mid;   // melting or freezing path
        logic               neg;   // quotient sign
    } ctx_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = S32_MAX;
        end else if (v < -64'sd2147483648) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [LH_W-1:0] lh_eff(input logic [LH_W-1:0] lh);
        logic [LH_W-1:0] r;
        r = (lh == '0) ? LH_W'(1) : lh;
        return r;
    endfunction

endpackage

// ===== rtl/core/ice_water_phase_update_top.sv =====
// ----------------------------------------------------------------------------
// ice_water_phase_update_top
// Per-particle temperature, heat and phase update, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   One particle enters per s_ transaction and exactly one result leaves per
//   m_ transaction, in the same order. From acceptance to m_tvalid a particle
//   passes two front stages, a 32-stage restoring divider (one quotient
//   bit per stage, shared by the blend term and the heat-to-temperature
//   conversion) and four back stages ending in the output register.
//   Throughput is one particle per cycle while the output is not stalled.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken; when the receiver stalls with a result waiting,
//   every stage holds and s_tready drops, so nothing is lost or repeated.
//   Configuration (latent heat, clamps) is written through cfg_we/cfg_addr/
//   cfg_wdata while no transaction is in flight.
//   Reset (aresetn low, synchronous) empties the pipeline and loads the
//   register defaults: latent heat 334.0, clamps [0.0, 1000.0].
// ----------------------------------------------------------------------------
module ice_water_phase_update_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // particle_index[11:0], temperature[43:12], heat[75:44], phase[77:76],
    // temp_delta[109:78], changed_before[110], zero[111]
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // particle_tag[11:0], new_temperature[43:12], new_heat[75:44],
    // new_phase[77:76], phase_changed[78], zero[79]
    output logic [79:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    localparam logic [1:0] REG_LATENT = 2'd0;
    localparam logic [1:0] REG_TUPPER = 2'd1;
    localparam logic [1:0] REG_TLOWER = 2'd2;

    localparam int PW = $bits(iwpu_pkg::ctx_t);

    logic [iwpu_pkg::LH_W-1:0]  latent_reg;
    logic signed [31:0]         upper_reg;
    logic signed [31:0]         lower_reg;

    logic                       adv;
    iwpu_pkg::ctx_t             in_ctx;
    logic                       f_valid;
    logic [iwpu_pkg::DVD_W-1:0] f_dvd;
    logic [iwpu_pkg::DVS_W-1:0] f_dvs;
    iwpu_pkg::ctx_t             f_ctx;
    logic                       d_valid;
    logic [iwpu_pkg::QUO_W-1:0] d_quo;
    logic                       d_ovf;
    logic [PW-1:0]              d_pay;
    iwpu_pkg::ctx_t             o_ctx;
    logic                       o_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latent_reg <= 31'd21889024;
            upper_reg  <= 32'sd65536000;
            lower_reg  <= 32'sd0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_LATENT: latent_reg <= cfg_wdata[iwpu_pkg::LH_W-1:0];
                REG_TUPPER: upper_reg  <= $signed(cfg_wdata);
                REG_TLOWER: lower_reg  <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign adv      = !o_valid || m_tready;
    assign s_tready = adv;

    always_comb begin
        in_ctx.tag   = s_tdata[11:0];
        in_ctx.temp  = $signed(s_tdata[43:12]);
        in_ctx.heat  = $signed(s_tdata[75:44]);
        in_ctx.phase = s_tdata[77:76];
        in_ctx.dt    = $signed(s_tdata[109:78]);
        in_ctx.flag  = s_tdata[110];
        in_ctx.mid   = 1'b0;
        in_ctx.neg   = 1'b0;
    end

    iwpu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_valid    (s_tvalid),
        .in_ctx      (in_ctx),
        .latent_heat (latent_reg),
        .out_valid   (f_valid),
        .out_dvd     (f_dvd),
        .out_dvs     (f_dvs),
        .out_ctx     (f_ctx)
    );

    iwpu_div #(
        .DVD_W (iwpu_pkg::DVD_W),
        .DVS_W (iwpu_pkg::DVS_W),
        .QW    (iwpu_pkg::QUO_W),
        .PW    (PW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_dvd    (f_dvd),
        .in_dvs    (f_dvs),
        .in_pay    (f_ctx),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_ovf   (d_ovf),
        .out_pay   (d_pay)
    );

    iwpu_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_valid    (d_valid),
        .in_quo      (d_quo),
        .in_ovf      (d_ovf),
        .in_ctx      (iwpu_pkg::ctx_t'(d_pay)),
        .latent_heat (latent_reg),
        .temp_upper  (upper_reg),
        .temp_lower  (lower_reg),
        .out_valid   (o_valid),
        .out_ctx     (o_ctx)
    );

    assign m_tvalid = o_valid;
    assign m_tdata  = {1'b0, o_ctx.flag, o_ctx.phase, o_ctx.heat, o_ctx.temp, o_ctx.tag};

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // solid and liquid results carry no heat
    a_settled_heat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (o_ctx.phase == iwpu_pkg::PH_ICE || o_ctx.phase == iwpu_pkg::PH_WATER)
        |-> o_ctx.heat == 32'sd0)
        else $error("nonzero heat in ice or water result");

    // a particle still freezing holds heat within [0, latent heat]
    a_freeze_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && o_ctx.phase == iwpu_pkg::PH_FREEZE
        |-> o_ctx.heat >= 32'sd0 &&
            o_ctx.heat <= $signed({1'b0, iwpu_pkg::lh_eff(latent_reg)}))
        else $error("freezing heat out of range");

    // the divider output holds while the pipeline is stalled
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(d_quo) && $stable(d_valid))
        else $error("divider moved during stall");

endmodule

// ===== rtl/core/iwpu_div.sv =====
// ----------------------------------------------------------------------------
// iwpu_div
// Pipelined restoring divider, one quotient bit per stage, payload carried.
// ----------------------------------------------------------------------------
module iwpu_div #(
    parameter int DVD_W = 50,
    parameter int DVS_W = 31,
    parameter int QW    = 32,
    parameter int PW    = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [DVD_W-1:0] in_dvd,
    input  logic [DVS_W-1:0] in_dvs,
    input  logic [PW-1:0]    in_pay,
    output logic             out_valid,
    output logic [QW-1:0]    out_quo,
    output logic             out_ovf,
    output logic [PW-1:0]    out_pay
);

    logic [QW-1:0]    valid_reg;
    logic [DVS_W-1:0] rem_reg   [QW];
    logic [QW-1:0]    low_reg   [QW];
    logic [QW-1:0]    quo_reg   [QW];
    logic [DVS_W-1:0] dvs_reg   [QW];
    logic             ovf_reg   [QW];
    logic [PW-1:0]    pay_reg   [QW];

    logic [DVS_W-1:0] rem_next  [QW];
    logic [QW-1:0]    low_next  [QW];
    logic [QW-1:0]    quo_next  [QW];
    logic [DVS_W-1:0] dvs_next  [QW];
    logic             ovf_next  [QW];
    logic [PW-1:0]    pay_next  [QW];

    logic [DVS_W-1:0] src_rem   [QW];
    logic [QW-1:0]    src_low   [QW];
    logic [QW-1:0]    src_quo   [QW];
    logic [DVS_W-1:0] src_dvs   [QW];
    logic             src_ovf   [QW];
    logic [PW-1:0]    src_pay   [QW];
    logic [DVS_W:0]   trial     [QW];
    logic [DVS_W:0]   diff      [QW];
    logic             ge        [QW];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                // quotient overflows when the high part already reaches the divisor
                src_rem[k] = DVS_W'(in_dvd[DVD_W-1:QW]);
                src_low[k] = in_dvd[QW-1:0];
                src_quo[k] = '0;
                src_dvs[k] = in_dvs;
                src_ovf[k] = (DVS_W'(in_dvd[DVD_W-1:QW]) >= in_dvs);
                src_pay[k] = in_pay;
            end else begin
                src_rem[k] = rem_reg[k-1];
                src_low[k] = low_reg[k-1];
                src_quo[k] = quo_reg[k-1];
                src_dvs[k] = dvs_reg[k-1];
                src_ovf[k] = ovf_reg[k-1];
                src_pay[k] = pay_reg[k-1];
            end
            trial[k]    = {src_rem[k], src_low[k][QW-1]};
            ge[k]       = trial[k] >= {1'b0, src_dvs[k]};
            diff[k]     = trial[k] - {1'b0, src_dvs[k]};
            rem_next[k] = ge[k] ? diff[k][DVS_W-1:0] : trial[k][DVS_W-1:0];
            low_next[k] = src_low[k] << 1;
            quo_next[k] = {src_quo[k][QW-2:0], ge[k]};
            dvs_next[k] = src_dvs[k];
            ovf_next[k] = src_ovf[k];
            pay_next[k] = src_pay[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[QW-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            quo_reg <= quo_next;
            dvs_reg <= dvs_next;
            ovf_reg <= ovf_next;
            pay_reg <= pay_next;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_ovf   = ovf_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

endmodule

// ===== rtl/core/iwpu_front.sv =====
// ----------------------------------------------------------------------------
// iwpu_front
// Phase entry, then dividend/divisor setup for the shared divider.
// ----------------------------------------------------------------------------
module iwpu_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  iwpu_pkg::ctx_t               in_ctx,
    input  logic [iwpu_pkg::LH_W-1:0]    latent_heat,
    output logic                         out_valid,
    output logic [iwpu_pkg::DVD_W-1:0]   out_dvd,
    output logic [iwpu_pkg::DVS_W-1:0]   out_dvs,
    output iwpu_pkg::ctx_t               out_ctx
);

    logic [iwpu_pkg::LH_W-1:0]  lh;
    iwpu_pkg::ctx_t             c1_next;
    iwpu_pkg::ctx_t             c1_reg;
    logic                       v1_reg;

    iwpu_pkg::ctx_t             c2_next;
    logic signed [49:0]         prod;
    logic signed [49:0]         h_x;
    logic signed [31:0]         k;
    logic [iwpu_pkg::DVD_W-1:0] dvd_next;
    logic [iwpu_pkg::DVS_W-1:0] dvs_next;

    logic                       v2_reg;
    iwpu_pkg::ctx_t             c2_reg;
    logic [iwpu_pkg::DVD_W-1:0] dvd_reg;
    logic [iwpu_pkg::DVS_W-1:0] dvs_reg;

    assign lh = iwpu_pkg::lh_eff(latent_heat);

    // stage 1: phase entry
    always_comb begin
        c1_next = in_ctx;
        if (in_ctx.phase == iwpu_pkg::PH_ICE && in_ctx.temp > iwpu_pkg::T_250) begin
            c1_next.phase = iwpu_pkg::PH_MELT;
            c1_next.temp  = iwpu_pkg::T_250;
            c1_next.heat  = '0;
        end else if (in_ctx.phase == iwpu_pkg::PH_WATER &&
                     in_ctx.temp < iwpu_pkg::T_250) begin
            c1_next.phase = iwpu_pkg::PH_FREEZE;
            c1_next.temp  = iwpu_pkg::T_250;
            c1_next.heat  = {1'b0, lh};
        end
        c1_next.mid = (c1_next.phase == iwpu_pkg::PH_MELT) ||
                      (c1_next.phase == iwpu_pkg::PH_FREEZE);
        c1_next.neg = 1'b0;
    end

    // stage 2: blend numerator or heat-to-temperature numerator
    always_comb begin
        c2_next = c1_reg;
        h_x     = 50'(c1_reg.heat);
        k       = (c1_reg.temp > iwpu_pkg::T_250) ? iwpu_pkg::C_4P2 : iwpu_pkg::C_2P1;
        if (c1_reg.mid) begin
            prod     = h_x * 50'(iwpu_pkg::C_2P1);
            dvs_next = lh;
        end else begin
            prod     = h_x <<< 16;
            dvs_next = iwpu_pkg::DVS_W'(k);
        end
        c2_next.neg = prod[49];
        dvd_next    = prod[49] ? iwpu_pkg::DVD_W'(-prod) : iwpu_pkg::DVD_W'(prod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg  <= c1_next;
            c2_reg  <= c2_next;
            dvd_reg <= dvd_next;
            dvs_reg <= dvs_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_dvd   = dvd_reg;
    assign out_dvs   = dvs_reg;
    assign out_ctx   = c2_reg;

endmodule

// ===== rtl/core/iwpu_back.sv =====
// ----------------------------------------------------------------------------
// iwpu_back
// Quotient signing, heat gain or temperature update, phase rules, output reg.
// ----------------------------------------------------------------------------
module iwpu_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [iwpu_pkg::QUO_W-1:0]   in_quo,
    input  logic                         in_ovf,
    input  iwpu_pkg::ctx_t               in_ctx,
    input  logic [iwpu_pkg::LH_W-1:0]    latent_heat,
    input  logic signed [31:0]           temp_upper,
    input  logic signed [31:0]           temp_lower,
    output logic                         out_valid,
    output iwpu_pkg::ctx_t               out_ctx
);

    logic [iwpu_pkg::LH_W-1:0] lh;
    logic                      big;
    logic signed [31:0]        q_s;
    iwpu_pkg::ctx_t            c3_next, c3_reg;
    logic signed [31:0]        spec_next, spec_reg;
    iwpu_pkg::ctx_t            c4_next, c4_reg;
    logic signed [63:0]        prod_next, prod_reg;
    logic signed [31:0]        t_sum;
    iwpu_pkg::ctx_t            c5_next, c5_reg;
    logic signed [31:0]        gain;
    iwpu_pkg::ctx_t            c6_next, out_reg;
    logic signed [33:0]        neg_h;
    logic signed [43:0]        rev_lim;
    logic                      rev_melt;
    logic                      v3_reg, v4_reg, v5_reg, out_valid_reg;

    assign lh = iwpu_pkg::lh_eff(latent_heat);

    // stage 3: signed, saturated quotient
    always_comb begin
        big = in_ovf || (in_ctx.neg ? (in_quo > 32'h8000_0000) : in_quo[31]);
        if (big) begin
            q_s = in_ctx.neg ? iwpu_pkg::S32_MIN : iwpu_pkg::S32_MAX;
        end else begin
            q_s = in_ctx.neg ? -$signed(in_quo) : $signed(in_quo);
        end
        c3_next   = in_ctx;
        spec_next = iwpu_pkg::sat32(64'(iwpu_pkg::C_2P1) + 64'(q_s));
        if (!in_ctx.mid) begin
            c3_next.temp = iwpu_pkg::sat32(64'(in_ctx.temp) + 64'(q_s));
        end
    end

    // stage 4: heat gain product, or add change and clamp
    always_comb begin
        c4_next   = c3_reg;
        prod_next = 64'(c3_reg.dt) * 64'(spec_reg);
        t_sum     = iwpu_pkg::sat32(64'(c3_reg.temp) + 64'(c3_reg.dt));
        if (!c3_reg.mid) begin
            if (t_sum > temp_upper) begin
                t_sum = temp_upper;
            end
            if (t_sum < temp_lower) begin
                t_sum = temp_lower;
            end
            c4_next.temp = t_sum;
            c4_next.heat = '0;
        end
    end

    // stage 5: floor to Q16.16 and accumulate
    always_comb begin
        c5_next = c4_reg;
        gain    = iwpu_pkg::sat32(prod_reg >>> 16);
        if (c4_reg.mid) begin
            c5_next.heat = iwpu_pkg::sat32(64'(c4_reg.heat) + 64'(gain));
        end
    end

    // stage 6: reversal and completion rules
    always_comb begin
        c6_next  = c5_reg;
        neg_h    = -34'(c5_reg.heat);
        rev_lim  = 44'(neg_h) * 44'sd300;
        // heat < -(lh/300) rewritten without the division
        rev_melt = c5_reg.heat < 0 && rev_lim > $signed({13'b0, lh});
        if (c5_reg.mid) begin
            if (c6_next.phase == iwpu_pkg::PH_MELT && rev_melt) begin
                c6_next.phase = iwpu_pkg::PH_ICE;
                c6_next.temp  = iwpu_pkg::T_249;
                c6_next.heat  = '0;
            end else if (c6_next.phase == iwpu_pkg::PH_FREEZE &&
                         c6_next.heat > $signed({1'b0, lh})) begin
                c6_next.phase = iwpu_pkg::PH_WATER;
                c6_next.temp  = iwpu_pkg::T_251;
                c6_next.heat  = '0;
            end
            if (c6_next.phase == iwpu_pkg::PH_MELT &&
                c6_next.heat > $signed({1'b0, lh})) begin
                c6_next.phase = iwpu_pkg::PH_WATER;
                c6_next.temp  = iwpu_pkg::T_251;
                c6_next.heat  = '0;
                c6_next.flag  = 1'b1;
            end else if (c6_next.phase == iwpu_pkg::PH_FREEZE && c6_next.heat < 0) begin
                c6_next.phase = iwpu_pkg::PH_ICE;
                c6_next.temp  = iwpu_pkg::T_249;
                c6_next.heat  = '0;
                c6_next.flag  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v3_reg        <= in_valid;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c3_reg   <= c3_next;
            spec_reg <= spec_next;
            c4_reg   <= c4_next;
            prod_reg <= prod_next;
            c5_reg   <= c5_next;
            out_reg  <= c6_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ctx   = out_reg;

endmodule
